// ===== hdl/gcd_pkg.sv =====
package gcd_pkg;

    // Angles in degrees times 65536
    localparam logic signed [26:0] DEG_FULL    = 27'sd23592960;
    localparam logic signed [26:0] DEG_HALF    = 27'sd11796480;
    localparam logic signed [26:0] DEG_QUARTER = 27'sd5898240;

    // Q2.30 constants
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

    // Degree to radian scaling. 180 * 65536 = 45 * 2^18, and pi in Q2.30
    // (3373259426) = 45 * PI_DIV45 + PI_MOD45. The leftover part is divided
    // by 45 through RECIP45 = ceil(2^34 / 45), exact below 2^28.
    localparam logic [26:0] PI_DIV45 = 27'd74961320;
    localparam logic [4:0]  PI_MOD45 = 5'd26;
    localparam logic [28:0] RECIP45  = 29'd381774871;

    localparam int ATAN_LEN = 32;
    localparam int QDEPTH   = 4;

    localparam logic [31:0] ATAN_Q30 [0:ATAN_LEN-1] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    // Reduced angle: in [-90, 90] degrees, flip set when folded by 180
    typedef struct packed {
        logic signed [23:0] m;
        logic               flip;
    } red_t;

    // One queue entry: three angles in Q2.30 radians (lat1, lat2, dlon)
    typedef struct packed {
        logic [2:0][31:0] z;
        logic [2:0]       flip;
    } q_t;

    function automatic red_t reduce_deg(input logic signed [26:0] d);
        logic signed [26:0] r;
        red_t               o;
        r      = d;
        o.flip = 1'b0;
        if (r >= DEG_FULL) begin
            r = r - DEG_FULL;
        end else if (r <= -DEG_FULL) begin
            r = r + DEG_FULL;
        end
        if (r < 0) begin
            r = r + DEG_FULL;
        end
        if (r > DEG_HALF) begin
            r = r - DEG_FULL;
        end
        if (r > DEG_QUARTER) begin
            r      = r - DEG_HALF;
            o.flip = 1'b1;
        end else if (r < -DEG_QUARTER) begin
            r      = r + DEG_HALF;
            o.flip = 1'b1;
        end
        o.m = r[23:0];
        return o;
    endfunction

    // Q2.30 product, round by adding one half then floor
    function automatic logic signed [33:0] mul_q30(input logic signed [33:0] a,
                                                   input logic signed [33:0] b);
        logic signed [67:0] p;
        p = (a * b + 68'sd536870912) >>> 30;
        return p[33:0];
    endfunction

endpackage

// ===== hdl/gcd_front.sv =====
module gcd_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [23:0] s_first_latitude,
    input  logic signed [24:0] s_first_longitude,
    input  logic signed [23:0] s_second_latitude,
    input  logic signed [24:0] s_second_longitude,
    output logic               q_valid,
    output gcd_pkg::q_t        q_data,
    input  logic               q_ready
);
    import gcd_pkg::*;

    localparam int FTOT = 4;

    logic [FTOT-1:0]    vld_reg;
    logic               adv;
    logic signed [25:0] dlon_diff;
    logic signed [25:0] dlon_abs;
    logic signed [26:0] ang_in [0:2];

    red_t               red_reg  [0:2];
    logic               neg1_reg [0:2];
    logic               neg2_reg [0:2];
    logic               flp1_reg [0:2];
    logic               flp2_reg [0:2];
    logic               flp3_reg [0:2];
    logic [49:0]        mq1_reg  [0:2];
    logic [49:0]        mq2_reg  [0:2];
    logic [27:0]        sr_reg   [0:2];
    logic [21:0]        qs_reg   [0:2];
    logic [31:0]        z_reg    [0:2];

    assign adv     = !vld_reg[FTOT-1] || q_ready;
    assign s_ready = adv;
    assign q_valid = vld_reg[FTOT-1];
    assign q_data  = {z_reg[2], z_reg[1], z_reg[0], flp3_reg[2], flp3_reg[1], flp3_reg[0]};

    assign dlon_diff = 26'(s_second_longitude) - 26'(s_first_longitude);
    assign dlon_abs  = dlon_diff[25] ? -dlon_diff : dlon_diff;
    assign ang_in[0] = 27'(s_first_latitude);
    assign ang_in[1] = 27'(s_second_latitude);
    assign ang_in[2] = 27'(dlon_abs);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[FTOT-2:0], s_valid};
        end
    end

    // z = round(|m| * pi / (45 * 2^18)), sign restored at the end
    for (genvar gl = 0; gl < 3; gl++) begin : g_lane
        logic [22:0] mag;
        logic [56:0] qprod;
        logic [49:0] zsum;

        assign mag   = red_reg[gl].m[23] ? 23'(-red_reg[gl].m) : red_reg[gl].m[22:0];
        assign qprod = 57'(sr_reg[gl]) * 57'(RECIP45);
        assign zsum  = mq2_reg[gl] + 50'(qs_reg[gl]);

        always_ff @(posedge aclk) begin
            if (adv) begin
                red_reg[gl]  <= reduce_deg(ang_in[gl]);
                neg1_reg[gl] <= red_reg[gl].m[23];
                flp1_reg[gl] <= red_reg[gl].flip;
                mq1_reg[gl]  <= 50'(mag) * 50'(PI_DIV45);
                sr_reg[gl]   <= 28'(mag) * 28'(PI_MOD45) + 28'(DEG_QUARTER);
                neg2_reg[gl] <= neg1_reg[gl];
                flp2_reg[gl] <= flp1_reg[gl];
                mq2_reg[gl]  <= mq1_reg[gl];
                qs_reg[gl]   <= qprod[55:34];
                flp3_reg[gl] <= flp2_reg[gl];
                z_reg[gl]    <= neg2_reg[gl] ? -{1'b0, zsum[48:18]}
                                             : {1'b0, zsum[48:18]};
            end
        end
    end

endmodule

// ===== hdl/gcd_queue.sv =====
module gcd_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  gcd_pkg::q_t push_data,
    output logic        full,
    input  logic        pop,
    output gcd_pkg::q_t pop_data,
    output logic        empty
);
    import gcd_pkg::*;

    localparam int AW = $clog2(QDEPTH);

    q_t          mem_reg [0:QDEPTH-1];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   count_reg, count_next;

    assign full     = count_reg == (AW+1)'(QDEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem_reg[rd_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty) else $error("pop from empty queue");
    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");
`endif

endmodule

// ===== hdl/gcd_back.sv =====
module gcd_back #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_pop,
    input  gcd_pkg::q_t q_data,
    input  logic [23:0] radius,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [25:0] m_distance_m
);
    import gcd_pkg::*;

    localparam int NS  = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int TOT = 3 * NS + 8;

    logic [TOT-1:0] vld_reg;
    logic           adv;

    // sine/cosine rotation lanes: 0 lat1, 1 lat2, 2 dlon
    logic signed [33:0] rx_reg [0:NS][0:2];
    logic signed [33:0] ry_reg [0:NS][0:2];
    logic signed [33:0] rz_reg [0:NS][0:2];
    logic               rf_reg [0:NS][0:2];
    logic signed [33:0] cs_reg [0:2];
    logic signed [33:0] sn_reg [0:2];

    logic signed [33:0] t1_reg, p_reg, a_reg, b_reg, c1_reg, s1_reg;

    // magnitude vectoring
    logic signed [33:0] vx_reg [0:NS];
    logic signed [33:0] vy_reg [0:NS];
    logic signed [33:0] vt_reg [0:NS];
    logic signed [33:0] h_reg, ht3_reg;
    logic signed [33:0] h_mul;

    // angle vectoring
    logic signed [33:0] wx_reg [0:NS];
    logic signed [33:0] wy_reg [0:NS];
    logic signed [33:0] wz_reg [0:NS];
    logic               wzero_reg [0:NS];
    logic               whalf_reg [0:NS];

    logic signed [33:0] ang_sum;
    logic [32:0]        ang_reg;
    logic [57:0]        dprod;
    logic [25:0]        dist_reg;

    assign adv          = !vld_reg[TOT-1] || m_ready;
    assign q_pop        = adv && q_valid;
    assign m_valid      = vld_reg[TOT-1];
    assign m_distance_m = dist_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[TOT-2:0], q_valid};
        end
    end

    for (genvar gl = 0; gl < 3; gl++) begin : g_rot
        always_ff @(posedge aclk) begin
            if (adv) begin
                rx_reg[0][gl] <= GAIN_Q30;
                ry_reg[0][gl] <= '0;
                rz_reg[0][gl] <= 34'($signed(q_data.z[gl]));
                rf_reg[0][gl] <= q_data.flip[gl];
                cs_reg[gl]    <= rf_reg[NS][gl] ? -rx_reg[NS][gl] : rx_reg[NS][gl];
                sn_reg[gl]    <= rf_reg[NS][gl] ? -ry_reg[NS][gl] : ry_reg[NS][gl];
            end
        end
        for (genvar gi = 0; gi < NS; gi++) begin : g_it
            logic signed [33:0] dx, dy, da;
            assign dx = ry_reg[gi][gl] >>> gi;
            assign dy = rx_reg[gi][gl] >>> gi;
            assign da = $signed({2'b00, ATAN_Q30[gi]});
            always_ff @(posedge aclk) begin
                if (adv) begin
                    if (rz_reg[gi][gl] >= 0) begin
                        rx_reg[gi+1][gl] <= rx_reg[gi][gl] - dx;
                        ry_reg[gi+1][gl] <= ry_reg[gi][gl] + dy;
                        rz_reg[gi+1][gl] <= rz_reg[gi][gl] - da;
                    end else begin
                        rx_reg[gi+1][gl] <= rx_reg[gi][gl] + dx;
                        ry_reg[gi+1][gl] <= ry_reg[gi][gl] - dy;
                        rz_reg[gi+1][gl] <= rz_reg[gi][gl] + da;
                    end
                    rf_reg[gi+1][gl] <= rf_reg[gi][gl];
                end
            end
        end
    end

    // products of the three Vincenty terms
    always_ff @(posedge aclk) begin
        if (adv) begin
            t1_reg    <= mul_q30(cs_reg[1], sn_reg[2]);
            p_reg     <= mul_q30(cs_reg[1], cs_reg[2]);
            a_reg     <= mul_q30(cs_reg[0], sn_reg[1]);
            b_reg     <= mul_q30(sn_reg[0], sn_reg[1]);
            c1_reg    <= cs_reg[0];
            s1_reg    <= sn_reg[0];
            vx_reg[0] <= (t1_reg < 0) ? -t1_reg : t1_reg;
            vy_reg[0] <= a_reg - mul_q30(s1_reg, p_reg);
            vt_reg[0] <= b_reg + mul_q30(c1_reg, p_reg);
        end
    end

    for (genvar gi = 0; gi < NS; gi++) begin : g_v1
        logic signed [33:0] dx, dy;
        assign dx = vy_reg[gi] >>> gi;
        assign dy = vx_reg[gi] >>> gi;
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (vy_reg[gi] < 0) begin
                    vx_reg[gi+1] <= vx_reg[gi] - dx;
                    vy_reg[gi+1] <= vy_reg[gi] + dy;
                end else begin
                    vx_reg[gi+1] <= vx_reg[gi] + dx;
                    vy_reg[gi+1] <= vy_reg[gi] - dy;
                end
                vt_reg[gi+1] <= vt_reg[gi];
            end
        end
    end

    assign h_mul = mul_q30(vx_reg[NS], GAIN_Q30);

    always_ff @(posedge aclk) begin
        if (adv) begin
            h_reg   <= (h_mul < 0) ? '0 : h_mul;
            ht3_reg <= vt_reg[NS];
            // a negative t3 is turned by -90 degrees first
            wzero_reg[0] <= (h_reg == 0) && (ht3_reg == 0);
            wz_reg[0]    <= '0;
            if (ht3_reg < 0) begin
                wx_reg[0]    <= h_reg;
                wy_reg[0]    <= -ht3_reg;
                whalf_reg[0] <= 1'b1;
            end else begin
                wx_reg[0]    <= ht3_reg;
                wy_reg[0]    <= h_reg;
                whalf_reg[0] <= 1'b0;
            end
        end
    end

    for (genvar gi = 0; gi < NS; gi++) begin : g_v2
        logic signed [33:0] dx, dy, da;
        assign dx = wy_reg[gi] >>> gi;
        assign dy = wx_reg[gi] >>> gi;
        assign da = $signed({2'b00, ATAN_Q30[gi]});
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (wy_reg[gi] < 0) begin
                    wx_reg[gi+1] <= wx_reg[gi] - dx;
                    wy_reg[gi+1] <= wy_reg[gi] + dy;
                    wz_reg[gi+1] <= wz_reg[gi] - da;
                end else begin
                    wx_reg[gi+1] <= wx_reg[gi] + dx;
                    wy_reg[gi+1] <= wy_reg[gi] - dy;
                    wz_reg[gi+1] <= wz_reg[gi] + da;
                end
                wzero_reg[gi+1] <= wzero_reg[gi];
                whalf_reg[gi+1] <= whalf_reg[gi];
            end
        end
    end

    assign ang_sum = wz_reg[NS] + (whalf_reg[NS] ? HALF_PI_Q30 : 34'sd0);
    assign dprod   = 58'(radius) * 58'(ang_reg) + 58'd536870912;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ang_reg <= (wzero_reg[NS] || ang_sum < 0) ? '0 : ang_sum[32:0];
            dist_reg <= (dprod[57:56] != 2'b00) ? '1 : dprod[55:30];
        end
    end

endmodule

// ===== hdl/great_circle_distance_top.sv =====
// Great-circle distance between two points on a sphere (spherical Vincenty).
//
// Input channel (s_*): one transfer carries both points as signed latitude and
// longitude in degrees times 65536. Output channel (m_*): one transfer carries
// the distance in whole meters, saturated at 2^26 - 1.
// Config channel (cfg_*): write the sphere radius in meters; cfg_ready is
// always high. Write it only while the block is empty.
//
// Throughput: one pair per clock while m_ready stays high. The path runs through
// 4 front stages (angle reduction, degree-to-radian scaling by reciprocal
// multiply), the queue memory, and 3 * CORDIC_STEPS + 8 back stages (sin/cos
// rotation, term products, two vectoring passes, final radius multiply), with
// CORDIC_STEPS capped at the arctangent table length. Both ends are fully
// unrolled pipelines.
//
// A 4-entry queue sits between front and back. When a result waits with m_ready
// low, the back end holds; the front keeps taking transfers until the queue
// fills, and only then drops s_ready.
//
// Reset (aresetn low, synchronous) empties both pipelines and the queue and
// sets the radius to 6371000 m.
module great_circle_distance_top #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [23:0] s_first_latitude,
    input  logic signed [24:0] s_first_longitude,
    input  logic signed [23:0] s_second_latitude,
    input  logic signed [24:0] s_second_longitude,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [25:0]        m_distance_m,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [23:0]        cfg_data
);
    import gcd_pkg::*;

    logic [23:0] radius_reg;

    // front -> queue
    logic f_valid, f_ready;
    q_t   f_data;
    // queue -> back
    logic q_full, q_empty, q_pop;
    q_t   q_data;

    assign cfg_ready = 1'b1;
    assign f_ready   = !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= 24'd6371000;
        end else if (cfg_valid && cfg_ready) begin
            radius_reg <= cfg_data;
        end
    end

    gcd_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_first_latitude   (s_first_latitude),
        .s_first_longitude  (s_first_longitude),
        .s_second_latitude  (s_second_latitude),
        .s_second_longitude (s_second_longitude),
        .q_valid            (f_valid),
        .q_data             (f_data),
        .q_ready            (f_ready)
    );

    gcd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (f_valid && f_ready),
        .push_data (f_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    gcd_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (!q_empty),
        .q_pop        (q_pop),
        .q_data       (q_data),
        .radius       (radius_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_distance_m (m_distance_m)
    );

endmodule
